// ===== src/spp_pkg.sv =====
`timescale 1ns / 1ps

package spp_pkg;

  localparam int VALUE_W = 62;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int RESULT_W = 1 + 3 * VALUE_W;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - RESULT_W;

  // settings identifiers that the block keeps
  localparam logic [VALUE_W-1:0] ID_TABLE_CAPACITY = VALUE_W'(1);
  localparam logic [VALUE_W-1:0] ID_HEADER_LIST_SIZE = VALUE_W'(6);
  localparam logic [VALUE_W-1:0] ID_BLOCKED_STREAMS = VALUE_W'(7);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LIST_SIZE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKED_STREAMS = 2'd2;

  // varint length prefix codes
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_4 = 2'd2;
  localparam logic [1:0] LEN_8 = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] blocked_streams;
    logic [VALUE_W-1:0] header_list_size;
    logic [VALUE_W-1:0] table_capacity;
  } spp_values_t;

  typedef struct packed {
    spp_values_t values;
    logic        status;
  } spp_result_t;

endpackage

// ===== src/spp_decoder.sv =====
`timescale 1ns / 1ps

module spp_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [spp_pkg::BYTE_W-1:0] payload_byte,
  input  logic                       final_byte,
  input  spp_pkg::spp_values_t       defaults,
  output spp_pkg::spp_result_t       result
);
  import spp_pkg::*;

  logic               in_payload;
  logic               reading_value;
  logic [CNT_W-1:0]   bytes_remaining;
  logic [VALUE_W-1:0] accumulator;
  logic [VALUE_W-1:0] held_identifier;
  spp_values_t        cur;

  logic               start;
  logic               base_rv;
  logic [CNT_W-1:0]   base_br;
  logic [VALUE_W-1:0] base_acc;
  logic [VALUE_W-1:0] base_hid;
  spp_values_t        base_cur;

  logic               in_payload_next;
  logic               reading_value_next;
  logic [CNT_W-1:0]   bytes_remaining_next;
  logic [VALUE_W-1:0] accumulator_next;
  logic [VALUE_W-1:0] held_identifier_next;
  spp_values_t        cur_next;

  always_comb begin
    // first byte of a payload starts from the defaults with a clean decoder
    start    = !in_payload;
    base_cur = start ? defaults : cur;
    base_rv  = start ? 1'b0 : reading_value;
    base_br  = start ? '0 : bytes_remaining;
    base_acc = start ? '0 : accumulator;
    base_hid = start ? '0 : held_identifier;

    if (base_br == '0) begin
      accumulator_next = {{(VALUE_W-6){1'b0}}, payload_byte[5:0]};
      case (payload_byte[7:6])
        LEN_1:   bytes_remaining_next = CNT_W'(0);
        LEN_2:   bytes_remaining_next = CNT_W'(1);
        LEN_4:   bytes_remaining_next = CNT_W'(3);
        LEN_8:   bytes_remaining_next = CNT_W'(7);
        default: bytes_remaining_next = CNT_W'(0);
      endcase
    end else begin
      accumulator_next     = {base_acc[VALUE_W-BYTE_W-1:0], payload_byte};
      bytes_remaining_next = base_br - CNT_W'(1);
    end

    reading_value_next   = base_rv;
    held_identifier_next = base_hid;
    cur_next             = base_cur;

    if (bytes_remaining_next == '0) begin
      if (!base_rv) begin
        held_identifier_next = accumulator_next;
        reading_value_next   = 1'b1;
      end else begin
        if (base_hid == ID_TABLE_CAPACITY) begin
          cur_next.table_capacity = accumulator_next;
        end else if (base_hid == ID_HEADER_LIST_SIZE) begin
          cur_next.header_list_size = accumulator_next;
        end else if (base_hid == ID_BLOCKED_STREAMS) begin
          cur_next.blocked_streams = accumulator_next;
        end
        reading_value_next = 1'b0;
      end
      accumulator_next = '0;
    end

    in_payload_next = !final_byte;

    // truncated when an integer or a pair is left open
    result.status = (bytes_remaining_next != '0) || reading_value_next;
    result.values = cur_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      reading_value   <= 1'b0;
      bytes_remaining <= '0;
    end else if (step) begin
      in_payload      <= in_payload_next;
      reading_value   <= reading_value_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      accumulator     <= accumulator_next;
      held_identifier <= held_identifier_next;
      cur             <= cur_next;
    end
  end

endmodule

// ===== src/spp_out_reg.sv =====
`timescale 1ns / 1ps

module spp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  spp_pkg::spp_result_t load_result,
  output logic                 room,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output spp_pkg::spp_result_t m_result
);
  import spp_pkg::*;

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_result <= load_result;
    end
  end

endmodule

// ===== src/settings_payload_parser_unit.sv =====
`timescale 1ns / 1ps

// channel  | signals                                    | carries
// ---------+--------------------------------------------+------------------------------
// s        | s_tvalid s_tready s_tdata[7:0] s_tlast     | payload byte, final-byte flag
// m        | m_tvalid m_tready m_tdata[191:0]           | status and three settings
// cfg      | cfg_valid cfg_ready cfg_index cfg_data     | default value writes
//
// one byte per cycle sustained unless s stalls; the decode logic sits between the input
// register and the result register, so a final byte's result reaches m from the result register
// rst is synchronous and clears the handshake state, the decoder and the defaults
// s stalls only when a final byte waits in the input register while m holds an
// untaken result; non-final bytes keep flowing during an m stall
// cfg is always ready; defaults are latched at the first byte of each payload

module settings_payload_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  // payload byte requests
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] payload_byte
  input  logic                                s_tlast,  // final_byte
  // result requests
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] status, [62:1] table_capacity, [124:63] header_list_size,
  // [186:125] blocked_streams, [191:187] zero
  output logic [spp_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // default value writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [spp_pkg::VALUE_W-1:0]         cfg_data
);
  import spp_pkg::*;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  logic              advance;
  logic              room;
  spp_values_t       defaults;
  spp_result_t       step_result;
  spp_result_t       m_result;

  // a non-final byte never needs the result register
  assign advance  = in_valid && (!in_last || room);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // default registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      defaults <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TABLE_CAPACITY:   defaults.table_capacity   <= cfg_data;
        CFG_HEADER_LIST_SIZE: defaults.header_list_size <= cfg_data;
        CFG_BLOCKED_STREAMS:  defaults.blocked_streams  <= cfg_data;
        default: ;
      endcase
    end
  end

  spp_decoder u_decoder (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .payload_byte (in_byte),
    .final_byte   (in_last),
    .defaults     (defaults),
    .result       (step_result)
  );

  spp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && in_last),
    .load_result (step_result),
    .room        (room),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_result    (m_result)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}},
                    m_result.values.blocked_streams,
                    m_result.values.header_list_size,
                    m_result.values.table_capacity,
                    m_result.status};

  // input side only backs up behind a final byte facing a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && in_last && m_tvalid && !m_tready))
    else $error("input stalled without a blocked final byte");

  // every final byte taken by the decoder produces a result
  a_final_result: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> m_tvalid)
    else $error("final byte did not produce a result");

  // a waiting result is never dropped by a non-final byte
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && !(advance && in_last)) |=> m_tvalid)
    else $error("pending result lost");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

// ===== bench/settings_payload_parser_unit_tb.sv =====
`timescale 1ns / 1ps

module settings_payload_parser_unit_tb;
  import spp_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 7;
  // a final byte passes the input and result registers before m; leave margin
  localparam int SETTLE_CYCLES = 6;
  // long receiver hold-off so a final byte backs up into s
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 250000;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 138;
  localparam int GAP_PCT = 11;
  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef enum logic [0:0] {STEP_BYTE, STEP_CFG} step_kind_t;

  // one row of the directed plan
  typedef struct packed {
    step_kind_t               kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [VALUE_W-1:0]       value;
    logic [7:0]               data;
    logic                     last;
    logic                     typed;  // want holds a hand-written result
    spp_result_t              want;
  } step_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;
  logic                         s_tlast = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]       m_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_W-1:0]       cfg_index = '0;
  logic [VALUE_W-1:0]           cfg_data = '0;

  // run control
  logic                         gaps_on = 1'b1;
  int                           hold_asked = 0;
  int                           hold_taken = 0;
  int                           hold_left = 0;
  int                           cycle_count = 0;
  int                           errors = 0;
  int                           bytes_sent = 0;

  // results still owed by the block, oldest first
  spp_result_t                  pending_settings_q[$];
  step_t                        plan_q[$];
  logic [7:0]                   payload_q[$];

  // predictor state: defaults, decoder and the values of the open payload
  logic [VALUE_W-1:0]           dflt_tc = '0;
  logic [VALUE_W-1:0]           dflt_hls = '0;
  logic [VALUE_W-1:0]           dflt_bs = '0;
  logic                         in_frame = 1'b0;
  logic                         want_value = 1'b0;
  logic [CNT_W-1:0]             bytes_left = '0;
  logic [VALUE_W-1:0]           acc = '0;
  logic [VALUE_W-1:0]           held_id = '0;
  logic [VALUE_W-1:0]           cur_tc = '0;
  logic [VALUE_W-1:0]           cur_hls = '0;
  logic [VALUE_W-1:0]           cur_bs = '0;

  settings_payload_parser_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic spp_result_t pack_settings(input logic st,
                                                input logic [VALUE_W-1:0] tc,
                                                input logic [VALUE_W-1:0] hls,
                                                input logic [VALUE_W-1:0] bs);
    spp_result_t r;
    r.status = st;
    r.values.table_capacity = tc;
    r.values.header_list_size = hls;
    r.values.blocked_streams = bs;
    return r;
  endfunction

  // values of every magnitude, from a few bits up to the full 62
  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'({$urandom, $urandom} >> $urandom_range(0, 63));
  endfunction

  // advance the decoder by one accepted byte; returns 1 when a result is due
  function automatic logic decode_payload_byte(input logic [7:0] b, input logic fin,
                                               output spp_result_t res);
    res = '0;
    // first byte of a payload latches the defaults and clears the decoder
    if (!in_frame) begin
      cur_tc = dflt_tc;
      cur_hls = dflt_hls;
      cur_bs = dflt_bs;
      want_value = 1'b0;
      bytes_left = '0;
      acc = '0;
      held_id = '0;
      in_frame = 1'b1;
    end
    if (bytes_left == 0) begin
      // length prefix: 1, 2, 4 or 8 bytes in total
      acc = VALUE_W'(b[5:0]);
      bytes_left = CNT_W'((4'd1 << b[7:6]) - 4'd1);
    end else begin
      acc = {acc[VALUE_W-9:0], b};
      bytes_left = bytes_left - 1'b1;
    end
    if (bytes_left == 0) begin
      if (!want_value) begin
        held_id = acc;
        want_value = 1'b1;
      end else begin
        // unknown identifiers drop out, repeats overwrite
        case (held_id)
          ID_TABLE_CAPACITY:   cur_tc = acc;
          ID_HEADER_LIST_SIZE: cur_hls = acc;
          ID_BLOCKED_STREAMS:  cur_bs = acc;
          default: ;
        endcase
        want_value = 1'b0;
      end
      acc = '0;
    end
    if (!fin) return 1'b0;
    // truncated when an integer is open or an identifier lacks its value
    res = pack_settings(bytes_left != 0 || want_value, cur_tc, cur_hls, cur_bs);
    in_frame = 1'b0;
    want_value = 1'b0;
    bytes_left = '0;
    acc = '0;
    held_id = '0;
    return 1'b1;
  endfunction

  function automatic void plan_byte(input logic [7:0] b);
    step_t st;
    st = '0;
    st.kind = STEP_BYTE;
    st.data = b;
    plan_q.push_back(st);
  endfunction

  function automatic void plan_end(input logic [7:0] b, input logic typed,
                                   input spp_result_t want);
    step_t st;
    st = '0;
    st.kind = STEP_BYTE;
    st.data = b;
    st.last = 1'b1;
    st.typed = typed;
    st.want = want;
    plan_q.push_back(st);
  endfunction

  function automatic void plan_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [VALUE_W-1:0] val);
    step_t st;
    st = '0;
    st.kind = STEP_CFG;
    st.idx = idx;
    st.value = val;
    plan_q.push_back(st);
  endfunction

  // append one variable-length integer, value cut to what the length holds
  function automatic void add_varint(input logic [VALUE_W-1:0] v, input logic [1:0] len);
    int n;
    int k;
    logic [63:0] w;
    n = 1 << len;
    w = 64'(v) & ((64'd1 << (8 * n - 2)) - 64'd1);
    w = w | (64'(len) << (8 * n - 2));
    for (k = n - 1; k >= 0; k--) payload_q.push_back(w[8*k +: 8]);
  endfunction

  // one byte request; valid stays high afterwards so back-to-back bytes flow
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input spp_result_t want);
    spp_result_t res;
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (decode_payload_byte(b, fin, res)) begin
      pending_settings_q.push_back(typed ? want : res);
    end
    bytes_sent++;
  endtask

  // default write request; caller drops cfg_valid after the last of a batch
  task automatic write_default(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TABLE_CAPACITY:   dflt_tc = val;
      CFG_HEADER_LIST_SIZE: dflt_hls = val;
      CFG_BLOCKED_STREAMS:  dflt_bs = val;
      default: ;
    endcase
  endtask

  // stop offering bytes and let every owed result drain
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_settings_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: check every accepted result, then pick next tready
  always @(posedge clk) begin : result_side
    spp_result_t got;
    spp_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[RESULT_W-1:0];
        if (pending_settings_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
          errors++;
        end else begin
          want = pending_settings_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.values.table_capacity !== want.values.table_capacity) begin
            $display("%0t: table_capacity expected %h, got %h", $time,
                     want.values.table_capacity, got.values.table_capacity);
            errors++;
          end
          if (got.values.header_list_size !== want.values.header_list_size) begin
            $display("%0t: header_list_size expected %h, got %h", $time,
                     want.values.header_list_size, got.values.header_list_size);
            errors++;
          end
          if (got.values.blocked_streams !== want.values.blocked_streams) begin
            $display("%0t: blocked_streams expected %h, got %h", $time,
                     want.values.blocked_streams, got.values.blocked_streams);
            errors++;
          end
          if (m_tdata[OUT_TDATA_W-1:RESULT_W] !== '0) begin
            $display("%0t: pad bits expected 0, got %h", $time,
                     m_tdata[OUT_TDATA_W-1:RESULT_W]);
            errors++;
          end
        end
      end
      // long hold-off on request, else random stalls
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (hold_asked != hold_taken) begin
        hold_taken <= hold_asked;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(gaps_on && $urandom_range(0, 99) < GAP_PCT);
      end
    end
  end

  initial begin : stimulus
    int r;
    int phase;
    int target;
    int shape;
    int cut;
    int k;
    logic [VALUE_W-1:0] ident;
    logic [VALUE_W-1:0] d0;
    logic [VALUE_W-1:0] d1;
    logic [VALUE_W-1:0] d2;

    // directed plan, defaults are zero out of reset
    // identifier with no value: truncated, reset defaults
    plan_end(8'h01, 1'b1, pack_settings(1'b1, '0, '0, '0));
    // table capacity from an 8-byte integer of all ones
    plan_byte(8'h01);
    repeat (7) plan_byte(8'hFF);
    plan_end(8'hFF, 1'b1, pack_settings(1'b0, VALUE_MAX, '0, '0));
    // all defaults to the top, plus a write to the unused index
    plan_cfg(CFG_TABLE_CAPACITY, VALUE_MAX);
    plan_cfg(CFG_HEADER_LIST_SIZE, VALUE_MAX);
    plan_cfg(CFG_BLOCKED_STREAMS, VALUE_MAX);
    plan_cfg(CFG_UNUSED, 62'h15);
    // unknown identifier, then blocked streams from a 4-byte integer
    plan_byte(8'h3F);
    plan_byte(8'h00);
    plan_byte(8'h07);
    plan_byte(8'hBF);
    plan_byte(8'hFF);
    plan_byte(8'hFF);
    plan_end(8'hFF, 1'b1, pack_settings(1'b0, VALUE_MAX, VALUE_MAX, 62'h3FFF_FFFF));
    // defaults rewritten mid payload, duplicate table capacity, 2-byte value
    plan_byte(8'h01);
    plan_byte(8'h0A);
    plan_byte(8'h06);
    plan_cfg(CFG_TABLE_CAPACITY, '0);
    plan_cfg(CFG_HEADER_LIST_SIZE, '0);
    plan_cfg(CFG_BLOCKED_STREAMS, '0);
    plan_byte(8'h7F);
    plan_byte(8'hFF);
    plan_byte(8'h01);
    plan_end(8'h14, 1'b0, '0);
    // payload ends inside a 2-byte integer
    plan_end(8'h40, 1'b1, pack_settings(1'b1, '0, '0, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < plan_q.size(); r++) begin
      if (plan_q[r].kind == STEP_CFG) begin
        if (r == 0 || plan_q[r-1].kind != STEP_CFG) settle();
        write_default(plan_q[r].idx, plan_q[r].value);
        if (r == plan_q.size() - 1 || plan_q[r+1].kind != STEP_CFG) cfg_valid <= 1'b0;
      end else begin
        send_byte(plan_q[r].data, plan_q[r].last, plan_q[r].typed, plan_q[r].want);
      end
    end

    // random phases, each with its own defaults
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        d0 = '0;
        d1 = '0;
        d2 = '0;
      end else if (phase == 1) begin
        d0 = VALUE_MAX;
        d1 = VALUE_MAX;
        d2 = VALUE_MAX;
      end else begin
        d0 = rand_value();
        d1 = rand_value();
        d2 = rand_value();
      end
      write_default(CFG_TABLE_CAPACITY, d0);
      write_default(CFG_HEADER_LIST_SIZE, d1);
      write_default(CFG_BLOCKED_STREAMS, d2);
      cfg_valid <= 1'b0;
      // one phase runs with no stalls at all
      gaps_on <= (phase != 3);
      // receiver holds off while bytes keep coming
      if (phase == 5) hold_asked <= hold_asked + 1;

      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        payload_q.delete();
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
          // raw noise
          repeat ($urandom_range(1, 12)) payload_q.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 4))
              0: ident = ID_TABLE_CAPACITY;
              1: ident = ID_HEADER_LIST_SIZE;
              2: ident = ID_BLOCKED_STREAMS;
              3: ident = VALUE_W'($urandom_range(0, 63));
              default: ident = rand_value();
            endcase
            add_varint(ident, 2'($urandom_range(LEN_1, LEN_8)));
            add_varint(rand_value(), 2'($urandom_range(LEN_1, LEN_8)));
          end
          // cut short somewhere inside the pairs
          if (shape < 20) begin
            cut = $urandom_range(1, payload_q.size() - 1);
            repeat (cut) void'(payload_q.pop_back());
          end
        end
        for (k = 0; k < payload_q.size(); k++) begin
          send_byte(payload_q[k], k == payload_q.size() - 1, 1'b0, '0);
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
